/* design/ubt_pkg.sv */
// shared types and constants for the uart block transmitter
package ubt_pkg;

	localparam int unsigned BUFFER_DEPTH_DEF = 128;
	localparam logic [7:0] COMPARE_RESET = 8'd208;
	localparam logic [3:0] FRAME_LEN = 4'd10;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef struct packed {
		logic       is_load;
		logic       is_last;
		logic [7:0] data;
	} q_item_t;

	typedef struct packed {
		logic tx_line;
		logic busy;
		logic refused;
		logic done;
	} res_t;

	typedef enum logic [2:0] {
		ST_EXEC  = 3'b001,
		ST_FETCH = 3'b010,
		ST_LOAD  = 3'b100
	} back_state_t;

endpackage

/* design/ubt_ram.sv */
// generic single-port ram with registered read
module ubt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = ubt_pkg::BUFFER_DEPTH_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

/* design/ubt_front.sv */
// input side: accepts items, classifies them and queues them for the back end
module ubt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output logic             q_valid,
	output ubt_pkg::q_item_t q_item,
	input  logic             q_pop
);

	ubt_pkg::q_item_t slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	ubt_pkg::q_item_t new_item;

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	always_comb begin
		new_item.is_load = (cmd == ubt_pkg::CMD_LOAD);
		new_item.is_last = (cmd == ubt_pkg::CMD_LOAD) && last_byte;
		new_item.data    = data_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/ubt_back.sv */
// back end: block buffer, bit timer and frame shifter
module ubt_back #(
	parameter int unsigned BUFFER_DEPTH = ubt_pkg::BUFFER_DEPTH_DEF,
	localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
	localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  ubt_pkg::q_item_t q_item,
	output logic             q_pop,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	output logic             res_valid,
	input  logic             res_ready,
	output ubt_pkg::res_t    res
);

	ubt_pkg::back_state_t state_q;
	logic [7:0]    compare_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] read_idx_q;
	logic [9:0]    frame_q;
	logic [3:0]    bit_idx_q;
	logic [7:0]    tick_q;
	logic          sending_q;
	logic          line_q;
	logic          pend_ref_q;
	logic          res_valid_q;
	ubt_pkg::res_t res_q;

	logic          slot_free;
	logic          go;
	logic          ram_en;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_rdata;
	logic          has_room;
	logic          match;
	logic [3:0]    bit_next;
	logic [9:0]    frame_shift;

	assign slot_free   = !res_valid_q || res_ready;
	assign go          = (state_q == ubt_pkg::ST_EXEC) && q_valid && slot_free;
	assign q_pop       = go;
	assign res_valid   = res_valid_q;
	assign res         = res_q;
	assign has_room    = (fill_q < CW'(BUFFER_DEPTH));
	assign match       = (tick_q == compare_q);
	assign bit_next    = bit_idx_q + 4'd1;
	assign frame_shift = frame_q >> bit_idx_q;

	always_comb begin
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = fill_q[AW-1:0];
		if (go && q_item.is_load && !sending_q && has_room) begin
			ram_en = 1'b1;
			ram_we = 1'b1;
		end else if (state_q == ubt_pkg::ST_FETCH) begin
			ram_en   = 1'b1;
			ram_addr = read_idx_q[AW-1:0];
		end
	end

	ubt_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_buf (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(q_item.data),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == ubt_pkg::ST_LOAD) begin
			frame_q <= {1'b1, ram_rdata, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ubt_pkg::ST_EXEC;
			compare_q   <= ubt_pkg::COMPARE_RESET;
			fill_q      <= '0;
			read_idx_q  <= '0;
			bit_idx_q   <= '0;
			tick_q      <= '0;
			sending_q   <= 1'b0;
			line_q      <= 1'b1;
			pend_ref_q  <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_we) begin
				compare_q <= cfg_wdata;
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ubt_pkg::ST_EXEC: begin
					if (go) begin
						if (q_item.is_load) begin
							if (sending_q) begin
								res_q       <= '{tx_line: line_q, busy: 1'b1,
									refused: 1'b1, done: 1'b0};
								res_valid_q <= 1'b1;
							end else begin
								if (has_room) begin
									fill_q <= fill_q + CW'(1);
								end
								if (q_item.is_last) begin
									read_idx_q <= '0;
									sending_q  <= 1'b1;
									pend_ref_q <= !has_room;
									state_q    <= ubt_pkg::ST_FETCH;
								end else begin
									res_q       <= '{tx_line: line_q, busy: 1'b0,
										refused: !has_room, done: 1'b0};
									res_valid_q <= 1'b1;
								end
							end
						end else if (sending_q && match) begin
							tick_q    <= '0;
							line_q    <= frame_shift[0];
							bit_idx_q <= bit_next;
							if (bit_next >= ubt_pkg::FRAME_LEN) begin
								if (read_idx_q < fill_q) begin
									pend_ref_q <= 1'b0;
									state_q    <= ubt_pkg::ST_FETCH;
								end else begin
									sending_q   <= 1'b0;
									fill_q      <= '0;
									read_idx_q  <= '0;
									bit_idx_q   <= '0;
									res_q       <= '{tx_line: frame_shift[0], busy: 1'b0,
										refused: 1'b0, done: 1'b1};
									res_valid_q <= 1'b1;
								end
							end else begin
								res_q       <= '{tx_line: frame_shift[0], busy: 1'b1,
									refused: 1'b0, done: 1'b0};
								res_valid_q <= 1'b1;
							end
						end else begin
							if (sending_q) begin
								tick_q <= tick_q + 8'd1;
							end
							res_q       <= '{tx_line: line_q, busy: sending_q,
								refused: 1'b0, done: 1'b0};
							res_valid_q <= 1'b1;
						end
					end
				end
				ubt_pkg::ST_FETCH: begin
					state_q <= ubt_pkg::ST_LOAD;
				end
				ubt_pkg::ST_LOAD: begin
					read_idx_q  <= read_idx_q + CW'(1);
					bit_idx_q   <= '0;
					tick_q      <= '0;
					res_q       <= '{tx_line: line_q, busy: 1'b1,
						refused: pend_ref_q, done: 1'b0};
					res_valid_q <= 1'b1;
					state_q     <= ubt_pkg::ST_EXEC;
				end
				default: begin
					state_q <= ubt_pkg::ST_EXEC;
				end
			endcase
		end
	end

endmodule

/* design/uart_block_transmitter_unit.sv */
// top level of the uart block transmitter
// Each transfer on the input is either one prescaled timer tick or one byte load; every item
// yields exactly one result with the line level, busy, refused and block_done flags. A
// two-entry queue decouples input from the execution side. Ticks and plain loads finish
// in the execution state alone, so with a ready consumer one item per cycle is sustained. A
// load marked last, and a tick that finishes a byte while more bytes wait, go through FETCH
// and LOAD, where the registered read of the single-port block buffer fetches the next byte.
// The buffer holds BUFFER_DEPTH bytes; loads beyond it, or while busy, are flagged refused.
// compare_value is written through cfg_we/cfg_wdata and resets to 208.
module uart_block_transmitter_unit #(
	parameter int unsigned BUFFER_DEPTH = ubt_pkg::BUFFER_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       tx_line,
	output logic       busy_res,
	output logic       refused,
	output logic       block_done,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic             q_valid;
	logic             q_pop;
	ubt_pkg::q_item_t q_item;
	ubt_pkg::res_t    res;

	ubt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	ubt_back #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.res_valid(out_valid),
		.res_ready(out_ready),
		.res      (res)
	);

	assign tx_line    = res.tx_line;
	assign busy_res   = res.busy;
	assign refused    = res.refused;
	assign block_done = res.done;

endmodule

/* design/ubt_checker.sv */
// port-level checker for the uart block transmitter, bound to the top level
module ubt_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic tx_line,
	input logic busy_res,
	input logic refused,
	input logic block_done
);

	a_done_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_done |-> !busy_res)
		else $error("block_done with busy still set");

	a_done_not_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(refused && block_done))
		else $error("refused and block_done together");

	a_idle_line_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> tx_line)
		else $error("line low while idle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_line) && $stable(busy_res)
			&& $stable(refused) && $stable(block_done))
		else $error("stalled result changed");

endmodule

bind uart_block_transmitter_unit ubt_checker u_ubt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.tx_line   (tx_line),
	.busy_res  (busy_res),
	.refused   (refused),
	.block_done(block_done)
);

/* tb/uart_block_transmitter_unit_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for the uart block transmitter: directed table, random blocks, full buffer
module uart_block_transmitter_unit_test;

	localparam int unsigned DEPTH       = ubt_pkg::BUFFER_DEPTH_DEF;
	localparam int unsigned IW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned HOLD_AT     = 300;
	localparam int unsigned HOLD_LEN    = 120;
	localparam int unsigned STEADY_FROM = 600;
	localparam int unsigned STEADY_TO   = 1400;

	localparam ubt_pkg::res_t RES_IDLE    = 4'b1000;
	localparam ubt_pkg::res_t RES_BUSY    = 4'b1100;
	localparam ubt_pkg::res_t RES_REFUSED = 4'b1110;
	localparam ubt_pkg::res_t RES_DONE    = 4'b1001;

	typedef struct packed {
		logic          is_cfg;
		logic [7:0]    cfg_val;
		logic          c;
		logic [7:0]    d;
		logic          l;
		logic [7:0]    reps;
		logic          has_exp;
		ubt_pkg::res_t exp_res;
	} dir_row_t;

	localparam int N_ROWS = 7;
	dir_row_t dir_rows [N_ROWS] = '{
		'{1'b0, 8'd0, ubt_pkg::CMD_TICK, 8'h00, 1'b0, 8'd1,  1'b1, RES_IDLE},
		'{1'b0, 8'd0, ubt_pkg::CMD_LOAD, 8'hFF, 1'b0, 8'd1,  1'b1, RES_IDLE},
		'{1'b0, 8'd0, ubt_pkg::CMD_LOAD, 8'h00, 1'b1, 8'd1,  1'b1, RES_BUSY},
		'{1'b0, 8'd0, ubt_pkg::CMD_LOAD, 8'h5A, 1'b1, 8'd1,  1'b1, RES_REFUSED},
		'{1'b1, 8'd0, ubt_pkg::CMD_TICK, 8'h00, 1'b0, 8'd0,  1'b0, RES_IDLE},
		'{1'b0, 8'd0, ubt_pkg::CMD_TICK, 8'h00, 1'b0, 8'd19, 1'b0, RES_IDLE},
		'{1'b0, 8'd0, ubt_pkg::CMD_TICK, 8'h00, 1'b0, 8'd1,  1'b1, RES_DONE}
	};

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic       cmd       = ubt_pkg::CMD_TICK;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       tx_line;
	logic       busy_res;
	logic       refused;
	logic       block_done;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;

	// predictor state
	logic [7:0] bit_time = ubt_pkg::COMPARE_RESET;
	logic [7:0] buf_mem [DEPTH];
	logic [8:0] fill_cnt = '0;
	logic [8:0] rd_idx   = '0;
	logic [9:0] frame_sr = '0;
	logic [3:0] bit_pos  = '0;
	logic [7:0] tick_cnt = '0;
	logic       tx_busy  = 1'b0;
	logic       line_lvl = 1'b1;

	ubt_pkg::res_t pending_line_states [$];
	int   error_count  = 0;
	int   results_seen = 0;
	int   cyc_count    = 0;
	int   idle_cycles  = 0;
	int   hold_left    = 0;
	bit   hold_done    = 1'b0;
	int   items_sent   = 0;
	int   refused_cnt  = 0;
	int   blocks_cnt   = 0;

	uart_block_transmitter_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tx_line    (tx_line),
		.busy_res   (busy_res),
		.refused    (refused),
		.block_done (block_done),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) cyc_count++;

	function automatic bit no_idle();
		return cyc_count >= STEADY_FROM && cyc_count < STEADY_TO;
	endfunction

	function automatic void load_next_frame();
		logic [7:0] b;
		b = (rd_idx < fill_cnt && rd_idx < DEPTH) ? buf_mem[rd_idx[IW-1:0]] : 8'h00;
		frame_sr = {1'b1, b, 1'b0};
		rd_idx++;
		bit_pos  = '0;
		tick_cnt = '0;
	endfunction

	function automatic ubt_pkg::res_t next_line_state(input logic c, input logic [7:0] d,
		input logic l);
		ubt_pkg::res_t r;
		r = '0;
		if (c == ubt_pkg::CMD_LOAD) begin
			if (tx_busy) begin
				r.refused = 1'b1;
			end else begin
				if (fill_cnt < DEPTH) begin
					buf_mem[fill_cnt[IW-1:0]] = d;
					fill_cnt++;
				end else begin
					r.refused = 1'b1;
				end
				if (l && fill_cnt > 0) begin
					rd_idx = '0;
					load_next_frame();
					tx_busy = 1'b1;
				end
			end
		end else if (tx_busy) begin
			if (tick_cnt == bit_time) begin
				tick_cnt = '0;
				line_lvl = frame_sr[bit_pos];
				bit_pos++;
				if (bit_pos >= ubt_pkg::FRAME_LEN) begin
					if (rd_idx < fill_cnt) begin
						load_next_frame();
					end else begin
						tx_busy  = 1'b0;
						fill_cnt = '0;
						rd_idx   = '0;
						bit_pos  = '0;
						r.done   = 1'b1;
					end
				end
			end else begin
				tick_cnt++;
			end
		end
		r.tx_line = line_lvl;
		r.busy    = tx_busy;
		return r;
	endfunction

	task automatic send_item(input logic c, input logic [7:0] d, input logic l,
		input bit has_exp, input ubt_pkg::res_t exp_res);
		ubt_pkg::res_t r;
		int   gap;
		r = next_line_state(c, d, l);
		if (r.refused)
			refused_cnt++;
		else
			items_sent++;
		if (r.done)
			blocks_cnt++;
		pending_line_states.push_back(has_exp ? exp_res : r);
		in_valid  <= 1'b1;
		cmd       <= c;
		data_byte <= d;
		last_byte <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		gap = (no_idle() || $urandom_range(0, 99) >= 32) ? 0 : $urandom_range(1, 2);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic tick();
		send_item(ubt_pkg::CMD_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
	endtask

	task automatic write_compare(input logic [7:0] v);
		in_valid <= 1'b0;
		while (pending_line_states.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		bit_time = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input logic [7:0] cmp, input int budget);
		int start;
		int k;
		write_compare(cmp);
		start = items_sent;
		while (items_sent - start < budget) begin
			if (tx_busy) begin
				if ($urandom_range(0, 9) == 0)
					send_item(ubt_pkg::CMD_LOAD, 8'($urandom), 1'($urandom), 1'b0, '0);
				else
					tick();
			end else if ($urandom_range(0, 99) < 80) begin
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
				repeat (k - 1) send_item(ubt_pkg::CMD_LOAD, 8'($urandom), 1'b0, 1'b0, '0);
				send_item(ubt_pkg::CMD_LOAD, 8'($urandom), 1'b1, 1'b0, '0);
			end else begin
				send_item(1'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
			end
		end
	endtask

	// fill to the top, overflow it, then start the send with a refused last byte
	task automatic full_buffer_phase();
		write_compare(8'd0);
		while (tx_busy) tick();
		while (fill_cnt < DEPTH) send_item(ubt_pkg::CMD_LOAD, 8'($urandom), 1'b0, 1'b0, '0);
		repeat (3) send_item(ubt_pkg::CMD_LOAD, 8'($urandom), 1'b0, 1'b0, '0);
		send_item(ubt_pkg::CMD_LOAD, 8'($urandom), 1'b1, 1'b0, '0);
		repeat (150) tick();
	endtask

	function automatic void check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			error_count++;
			$error("%s: expected %0b, got %0b", name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		ubt_pkg::res_t want;
		if (out_valid === 1'b1 && out_ready) begin
			results_seen++;
			if (pending_line_states.size() == 0) begin
				error_count++;
				$error("result transfer with nothing expected");
			end else begin
				want = pending_line_states.pop_front();
				check_field("tx_line", want.tx_line, tx_line);
				check_field("busy_res", want.busy, busy_res);
				check_field("refused", want.refused, refused);
				check_field("block_done", want.done, block_done);
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle() || $urandom_range(0, 99) >= 32;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL uart_block_transmitter_unit");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < N_ROWS; r++) begin
			if (dir_rows[r].is_cfg)
				write_compare(dir_rows[r].cfg_val);
			else
				repeat (dir_rows[r].reps)
					send_item(dir_rows[r].c, dir_rows[r].d, dir_rows[r].l,
						dir_rows[r].has_exp, dir_rows[r].exp_res);
		end
		random_phase(8'd1, 140);
		random_phase(8'd255, 200);
		random_phase(8'd0, 180);
		random_phase(8'd3, 140);
		random_phase(8'd2, 100);
		full_buffer_phase();
		in_valid <= 1'b0;
		while (pending_line_states.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("%0d items took effect, %0d loads refused, %0d blocks sent through",
			items_sent, refused_cnt, blocks_cnt);
		$display("bit periods from compare 0 to 255, full buffer overflow and long output stall");
		if (error_count == 0)
			$display("PASS uart_block_transmitter_unit");
		else
			$display("FAIL uart_block_transmitter_unit");
		$finish;
	end

endmodule

/* uart_block_transmitter_unit.f */
design/ubt_pkg.sv
design/ubt_ram.sv
design/ubt_front.sv
design/ubt_back.sv
design/uart_block_transmitter_unit.sv
design/ubt_checker.sv
tb/uart_block_transmitter_unit_test.sv
